// File: rtl/xs64_pkg.sv
// Shared types and constants for the xorshift64* random draw unit.
`timescale 1ns / 1ps

package xs64_pkg;

  localparam logic [63:0] MULT_CONST = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;
  localparam logic [63:0] SEED_RESET = 64'd1;

  localparam int unsigned PROB_W = 33;
  localparam int unsigned INT_W = 32;
  localparam int unsigned TDATA_W = 104;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic [63:0]        state;
    logic [PROB_W-1:0]  probability;
    logic [INT_W-1:0]   range_low;
    logic               diff_neg;
    logic [INT_W-1:0]   diff_mag;
  } draw_entry_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MUL_LL,
    PH_MUL_LH,
    PH_MUL_HL,
    PH_ACC,
    PH_MUL_FR,
    PH_DONE
  } phase_t;

endpackage

// File: rtl/xs64_front.sv
// Front end: generator state, shift-xor advance and request classification.
`timescale 1ns / 1ps

module xs64_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     seed_we,
  input  logic [63:0]              seed_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [xs64_pkg::TDATA_W-1:0] in_data,
  input  logic                     q_full,
  output logic                     q_push,
  output xs64_pkg::draw_entry_t    q_entry
);

  logic [63:0] state;
  logic [63:0] step_a;
  logic [63:0] step_b;
  logic [63:0] state_next;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [32:0] diff;
  logic [32:0] diff_abs;

  assign step_a     = state ^ (state >> xs64_pkg::SHIFT_A);
  assign step_b     = step_a ^ (step_a << xs64_pkg::SHIFT_B);
  assign state_next = step_b ^ (step_b >> xs64_pkg::SHIFT_C);

  assign range_low  = in_data[64:33];
  assign range_high = in_data[96:65];
  assign diff       = {range_high[31], range_high} - {range_low[31], range_low};
  assign diff_abs   = diff[32] ? (33'd0 - diff) : diff;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.state       = state_next;
    q_entry.probability = in_data[32:0];
    q_entry.range_low   = range_low;
    q_entry.diff_neg    = diff[32];
    q_entry.diff_mag    = diff_abs[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xs64_pkg::SEED_RESET;
    end else if (seed_we) begin
      state <= seed_wdata;
    end else if (q_push) begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/xs64_queue.sv
// Two-entry queue between the front end and the multiply back end.
`timescale 1ns / 1ps

module xs64_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  xs64_pkg::draw_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output xs64_pkg::draw_entry_t head_entry,
  output logic                  empty
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  xs64_pkg::draw_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W+1)'(DEPTH));
  assign empty      = (count == '0);
  assign head_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/xs64_back.sv
// Back end: shared 32x32 multiplier sequence, result shaping and output register.
`timescale 1ns / 1ps

module xs64_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  xs64_pkg::draw_entry_t        q_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [xs64_pkg::TDATA_W-1:0] out_data
);

  xs64_pkg::phase_t      phase;
  xs64_pkg::phase_t      phase_next;
  xs64_pkg::draw_entry_t work;
  logic [63:0] raw;
  logic [63:0] prod;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic        mul_en;
  logic        out_load;
  logic [33:0] a_ext;
  logic [33:0] w_ext;
  logic [33:0] s_pos;
  logic [33:0] s_neg;
  logic [33:0] s_fix;
  logic        has_frac;
  logic        coin;

  always_comb begin
    phase_next = phase;
    op_a       = work.state[31:0];
    op_b       = xs64_pkg::MULT_CONST[31:0];
    mul_en     = 1'b0;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (phase)
      xs64_pkg::PH_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          phase_next = xs64_pkg::PH_MUL_LL;
        end
      end
      xs64_pkg::PH_MUL_LL: begin
        mul_en     = 1'b1;
        phase_next = xs64_pkg::PH_MUL_LH;
      end
      xs64_pkg::PH_MUL_LH: begin
        op_b       = xs64_pkg::MULT_CONST[63:32];
        mul_en     = 1'b1;
        phase_next = xs64_pkg::PH_MUL_HL;
      end
      xs64_pkg::PH_MUL_HL: begin
        op_a       = work.state[63:32];
        mul_en     = 1'b1;
        phase_next = xs64_pkg::PH_ACC;
      end
      xs64_pkg::PH_ACC: begin
        phase_next = xs64_pkg::PH_MUL_FR;
      end
      xs64_pkg::PH_MUL_FR: begin
        op_a       = raw[31:0];
        op_b       = work.diff_mag;
        mul_en     = 1'b1;
        phase_next = xs64_pkg::PH_DONE;
      end
      xs64_pkg::PH_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          phase_next = xs64_pkg::PH_IDLE;
        end
      end
      default: phase_next = xs64_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= xs64_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Truncate a + F*(b-a) toward zero from the 32.32 magnitude product.
  assign has_frac = |prod[31:0];
  assign a_ext    = {{2{work.range_low[31]}}, work.range_low};
  assign w_ext    = {2'b00, prod[63:32]};
  assign s_pos    = a_ext + w_ext;
  assign s_neg    = a_ext - w_ext;

  always_comb begin
    if (!work.diff_neg) begin
      s_fix = (s_pos[33] && has_frac) ? s_pos + 34'd1 : s_pos;
    end else begin
      s_fix = (!s_neg[33] && (s_neg != '0) && has_frac) ? s_neg - 34'd1 : s_neg;
    end
  end

  assign coin = ({1'b0, raw[31:0]} < work.probability);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_entry;
    end
    if (mul_en) begin
      prod <= 64'(op_a) * 64'(op_b);
    end
    case (phase)
      xs64_pkg::PH_MUL_LH: raw <= prod;
      xs64_pkg::PH_MUL_HL,
      xs64_pkg::PH_ACC:    raw[63:32] <= raw[63:32] + prod[31:0];
      default:             raw <= raw;
    endcase
    if (out_load) begin
      out_data <= {7'd0, s_fix[31:0], coin, raw};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/xorshift64star_random_draw_unit.sv
// Top level of the xorshift64* random draw unit.
// The back end works on one word at a time, on its single shared 32x32
//   multiplier (three partial products for the raw value, one for the range),
//   and pops the next word from the queue only after loading the result word.
// Reset (rst, synchronous, active high): generator state loads 1, queue and
//   output register empty; no clearing pass.
`timescale 1ns / 1ps

module xorshift64star_random_draw_unit (
  input  logic         clk,
  input  logic         rst,
  // Seed register: a write loads the generator state directly.
  input  logic         seed_we,
  input  logic [63:0]  seed_wdata,
  // Request words.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [32:0] probability, [64:33] range_low, [96:65] range_high, [103:97] zero
  input  logic [103:0] s_axis_tdata,
  // Result words.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] raw_value, [64] coin_bit, [96:65] uniform_integer, [103:97] zero
  output logic [103:0] m_axis_tdata
);

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  xs64_pkg::draw_entry_t push_entry;
  xs64_pkg::draw_entry_t head_entry;

  // Front end: advance the state with the shift-xor steps on each accepted
  // word and work out the sign and magnitude of (high - low) up front.
  xs64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  // Short queue: lets the front keep taking words while the back end
  // multiplies or waits on a stalled output.
  xs64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  // Back end: form state * constant mod 2^64 from partial products, then
  // scale the low 32 bits by |high - low| and round toward zero.
  xs64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_entry   (head_entry),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: rtl/xs64_checker.sv
// Port-level checks for the xorshift64* random draw unit, bound to the top level.
`timescale 1ns / 1ps

module xs64_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // Reset empties the output register.
  a_reset_out_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  // Reset empties the queue, so requests are taken at once.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("request side not ready after reset");

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

endmodule

bind xorshift64star_random_draw_unit xs64_checker u_xs64_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
